[rtl/modexp_pkg.sv]
package modexp_pkg;

    // operand and residue width: base, result and the partial residue
    localparam int OP_W = 31;

    // effective modulus width: a programmed zero stands for 2^31
    localparam int MOD_W = 32;

    // exponent port width
    localparam int EXP_W = 32;

    // default number of exponent bits taken into account
    localparam int EXP_BITS_DEF = 32;

    // bit counter width for one serial multiplication
    localparam int CNT_W = $clog2(OP_W);

    // modulus register value after reset
    localparam logic [OP_W-1:0] MODULUS_RESET = OP_W'(1000000007);

    // modulus used when the register holds zero
    localparam logic [MOD_W-1:0] MOD_WRAP = MOD_W'(1) << OP_W;

    // multiplicative identity
    localparam logic [OP_W-1:0] OP_ONE = OP_W'(1);

endpackage

[rtl/modexp_mulmod.sv]
module modexp_mulmod
    import modexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OP_W-1:0]  op_a,
    input  logic [OP_W-1:0]  op_b,
    input  logic [MOD_W-1:0] modulus,
    output logic             done,
    output logic [OP_W-1:0]  product
);

    localparam int SUM_W = MOD_W + 2;

    logic [OP_W-1:0]  a_reg;
    logic [OP_W-1:0]  a_next;
    logic [OP_W-1:0]  b_reg;
    logic [OP_W-1:0]  b_next;
    logic [OP_W-1:0]  r_reg;
    logic [OP_W-1:0]  r_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    logic [SUM_W-1:0] sum_plain;
    logic [SUM_W-1:0] sum_less_m;
    logic [SUM_W-1:0] sum_less_2m;
    logic [OP_W-1:0]  r_step;

    // one multiplier bit per cycle, msb first: r = (2r + bit*b) mod m,
    // with 2r + b below 3m so one of three candidates is the residue
    always_comb
    begin
        sum_plain   = {2'b00, r_reg, 1'b0}
                    + (a_reg[OP_W-1] ? SUM_W'(b_reg) : SUM_W'(0));
        sum_less_m  = sum_plain - SUM_W'(modulus);
        sum_less_2m = sum_plain - {1'b0, modulus, 1'b0};
        if (!sum_less_2m[SUM_W-1])
        begin
            r_step = sum_less_2m[OP_W-1:0];
        end
        else if (!sum_less_m[SUM_W-1])
        begin
            r_step = sum_less_m[OP_W-1:0];
        end
        else
        begin
            r_step = sum_plain[OP_W-1:0];
        end
    end

    // sequencing of the serial pass
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = op_a;
            b_next    = op_b;
            r_next    = '0;
            cnt_next  = CNT_W'(OP_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next = a_reg << 1;
            r_next = r_step;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and partial residue registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

    // partial residue stays reduced during the pass
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, r_reg} < modulus))
        else $error("mulmod residue out of range");

    // every finished pass raises done exactly as busy drops
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("mulmod pass ended without done");

endmodule

[rtl/modular_exponentiation_top.sv]
// Modular exponentiation: result = base^exponent mod modulus, right-to-left binary method.
// The modulus is set through the cfg channel (31 bits, reset 1000000007; a value of zero
// means 2^31) and is sampled when a request is accepted. An exponent of zero, after only
// the low EXP_BITS bits are kept, returns 1 for any modulus. Two bit-serial modular
// multipliers run side by side, one bit of the multiplier operand per cycle, and each
// multiply-and-square step is one pass of both. A request first reduces the base in the
// squaring unit, then takes one step for every exponent bit up to its highest set bit,
// then loads the output register; a zero exponent goes straight to loading it. The next
// request can be accepted as soon as the result is loaded. One request is in work at a
// time; a finished result waits in the output register, a new request can be accepted
// meanwhile, and its own result is held back until the waiting one has been taken.
module modular_exponentiation_top
    import modexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [OP_W-1:0]  modulus,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OP_W-1:0]  base,
    input  logic [EXP_W-1:0] exponent,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OP_W-1:0]  result
);

    localparam int USED_BITS = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam logic [EXP_W-1:0] EXP_MASK = {EXP_W{1'b1}} >> (EXP_W - USED_BITS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_STEP   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             start_reg;
    logic             start_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OP_W-1:0]  modulus_reg;
    logic [OP_W-1:0]  cur_reg;
    logic [OP_W-1:0]  cur_next;
    logic [OP_W-1:0]  acc_reg;
    logic [OP_W-1:0]  acc_next;
    logic [EXP_W-1:0] e_reg;
    logic [EXP_W-1:0] e_next;
    logic [MOD_W-1:0] m_reg;
    logic [MOD_W-1:0] m_next;
    logic [OP_W-1:0]  result_reg;
    logic [OP_W-1:0]  result_next;

    logic [EXP_W-1:0] e_masked;
    logic [EXP_W-1:0] e_shift;
    logic [OP_W-1:0]  sq_op_b;
    logic             done_a;
    logic             done_b;
    logic [OP_W-1:0]  prod_a;
    logic [OP_W-1:0]  prod_b;

    // accumulator multiply: acc * cur mod m
    modexp_mulmod u_mul_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .op_a    (acc_reg),
        .op_b    (cur_reg),
        .modulus (m_reg),
        .done    (done_a),
        .product (prod_a)
    );

    // squaring unit, also reduces the base (base * 1 mod m) at the start
    assign sq_op_b = (state_reg == S_REDUCE) ? OP_ONE : cur_reg;

    modexp_mulmod u_mul_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .op_a    (cur_reg),
        .op_b    (sq_op_b),
        .modulus (m_reg),
        .done    (done_b),
        .product (prod_b)
    );

    assign e_masked = exponent & EXP_MASK;
    assign e_shift  = e_reg >> 1;

    // request sequencing
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        result_next    = result_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next = base;
                    acc_next = OP_ONE;
                    e_next   = e_masked;
                    m_next   = (modulus_reg == '0) ? MOD_WRAP : {1'b0, modulus_reg};
                    if (e_masked == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_REDUCE;
                        start_next = 1'b1;
                    end
                end
            end
            S_REDUCE:
            begin
                if (done_b)
                begin
                    cur_next   = prod_b;
                    state_next = S_STEP;
                    start_next = 1'b1;
                end
            end
            S_STEP:
            begin
                if (done_b)
                begin
                    if (e_reg[0])
                    begin
                        acc_next = prod_a;
                    end
                    cur_next = prod_b;
                    e_next   = e_shift;
                    if (e_shift == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        start_next = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    result_next    = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                modulus_reg <= modulus;
            end
        end
    end

    // working values and output data
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        acc_reg    <= acc_next;
        e_reg      <= e_next;
        m_reg      <= m_next;
        result_reg <= result_next;
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // both multipliers are started together and must finish together
    assert property (@(posedge clk) disable iff (!rst_n)
        done_a == done_b)
        else $error("multiplier passes out of step");

    // a fresh result is reduced, or the identity for a zero exponent
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (result_reg == OP_ONE || {1'b0, result_reg} < m_reg))
        else $error("result not reduced");

    // work only goes on while exponent bits remain
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE || state_reg == S_STEP) |-> (e_reg != '0))
        else $error("exponent exhausted while busy");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
    import modexp_pkg::*;
();

    localparam int EXP_USED     = EXP_BITS_DEF;
    localparam int DRAIN_CYCLES = 1100;

    // one expected power with the request that caused it
    typedef struct {
        logic [OP_W-1:0]  power;
        logic [OP_W-1:0]  base;
        logic [EXP_W-1:0] exponent;
        logic [OP_W-1:0]  modulus;
    } power_expect_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [OP_W-1:0]  modulus;
    logic             in_valid;
    logic             in_ready;
    logic [OP_W-1:0]  base;
    logic [EXP_W-1:0] exponent;
    logic             out_valid;
    logic             out_ready;
    logic [OP_W-1:0]  result;

    power_expect_t    power_q[$];
    logic [OP_W-1:0]  modulus_shadow = MODULUS_RESET;
    bit               src_idle_en = 1'b1;
    bit               sink_idle_en = 1'b1;
    int               hold_cycles = 0;
    int               fail_count = 0;
    int               requests_sent = 0;
    int               results_checked = 0;
    int               modulus_writes = 0;

    modular_exponentiation_top #(
        .EXP_BITS (EXP_USED)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .modulus   (modulus),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // clock
    always #6 clk = ~clk;

    // right-to-left square and multiply, zero register value means 2^31
    function automatic logic [OP_W-1:0] predict_power(input logic [OP_W-1:0] b,
                                                      input logic [EXP_W-1:0] e,
                                                      input logic [OP_W-1:0] m_reg);
        logic [63:0] m;
        logic [63:0] cur;
        logic [63:0] acc;
        logic [63:0] e_used;
        m      = (m_reg == '0) ? 64'(MOD_WRAP) : 64'(m_reg);
        e_used = 64'(e) & ((64'd1 << EXP_USED) - 64'd1);
        if (e_used == 64'd0)
            return OP_ONE;
        cur = 64'(b);
        acc = 64'd1;
        for (int i = 0; i < EXP_USED; i++)
        begin
            if (e_used[i])
                acc = (acc * cur) % m;
            cur = (cur * cur) % m;
        end
        return acc[OP_W-1:0];
    endfunction

    // mismatch reporting
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // send one request, with an optional idle burst ahead of it
    task automatic send_power(input logic [OP_W-1:0] b, input logic [EXP_W-1:0] e);
        power_expect_t item;
        int            gap;
        @(negedge clk);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (!in_ready);
        item.base     = b;
        item.exponent = e;
        item.modulus  = modulus_shadow;
        item.power    = predict_power(b, e, modulus_shadow);
        power_q.insert(power_q.size(), item);
        requests_sent++;
    endtask

    // drop the request valid after the last accepted request
    task automatic src_release();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // modulus write, only once every pending result has come back
    task automatic write_modulus(input logic [OP_W-1:0] value);
        src_release();
        wait (power_q.size() == 0);
        @(negedge clk);
        cfg_valid <= 1'b1;
        modulus   <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        modulus_shadow = value;
        modulus_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random base, biased toward edges and values below the modulus
    function automatic logic [OP_W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return OP_ONE;
            2: return '1;
            3: return modulus_shadow - OP_ONE;
            4, 5:
            begin
                if (modulus_shadow == '0)
                    return OP_W'($urandom);
                return OP_W'($urandom_range(0, modulus_shadow - 1));
            end
            default: return OP_W'($urandom);
        endcase
    endfunction

    // random exponent: edge values, full-width random or of random bit length
    function automatic logic [EXP_W-1:0] pick_exponent();
        int w;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return EXP_W'(1) << $urandom_range(0, EXP_W - 1);
            3, 4, 5: return EXP_W'($urandom);
            default:
            begin
                w = $urandom_range(1, EXP_W);
                return EXP_W'($urandom) & ({EXP_W{1'b1}} >> (EXP_W - w));
            end
        endcase
    endfunction

    // random modulus: full width, small, zero or all ones
    function automatic logic [OP_W-1:0] pick_modulus();
        case ($urandom_range(0, 7))
            4, 5: return OP_W'($urandom_range(2, 1000));
            6: return '0;
            7: return '1;
            default: return OP_W'($urandom);
        endcase
    endfunction

    // result receiver: long hold-off on request, else random ready and stall bursts
    initial
    begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && run_left == 0)
                begin
                    if (sink_idle_en && $urandom_range(0, 2) == 0)
                        stall_left = $urandom_range(1, 14);
                    else
                        run_left = $urandom_range(1, 24);
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    run_left--;
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        power_expect_t item;
        if (rst_n && out_valid && out_ready)
        begin
            if (power_q.size() == 0)
                report_mismatch($sformatf("result %0d with no request pending", result));
            else
            begin
                item = power_q.pop_front();
                results_checked++;
                if (result !== item.power)
                    report_mismatch($sformatf("result %0d, expected %0d for %0d^%0d mod %0d",
                                              result, item.power, item.base,
                                              item.exponent, item.modulus));
            end
        end
    end

    // edges under the reset modulus
    task automatic test_default_modulus();
        send_power('0, '0);
        send_power('1, '0);
        send_power('0, 32'd5);
        send_power(OP_ONE, '1);
        send_power('1, '1);
        send_power(31'd2, 32'd10);
        send_power(MODULUS_RESET - OP_ONE, 32'd2);
        send_power(31'h5555_5555, 32'h8000_0000);
    endtask

    // modulus of one: zero exponent still gives one
    task automatic test_modulus_one();
        write_modulus(OP_ONE);
        send_power(31'd7, '0);
        send_power('1, 32'd1);
        send_power('0, '1);
    endtask

    // zero register value wraps at 2^31
    task automatic test_modulus_wrap();
        write_modulus('0);
        send_power(31'd2, 32'd31);
        send_power(31'd2, 32'd30);
        send_power(31'd3, '1);
        send_power('1, 32'd2);
        send_power(31'h2AAA_AAAA, 32'h5555_5555);
    endtask

    // largest nonzero modulus, 2^31-1
    task automatic test_modulus_max();
        write_modulus('1);
        send_power('1, '1);
        send_power('1 - OP_ONE, '1);
        send_power(31'd12345, 32'h8000_0000);
        send_power(31'h4000_0000, 32'd3);
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_modulus(pick_modulus());
        src_idle_en = 1'b0;
        @(posedge clk);
        hold_cycles = 600;
        repeat (6)
            send_power(pick_base(), EXP_W'($urandom_range(1, 255)));
        src_idle_en = 1'b1;
    endtask

    // random requests over several modulus settings, idling on both sides
    task automatic test_random_phases();
        for (int p = 0; p < 7; p++)
        begin
            write_modulus(pick_modulus());
            repeat (36)
                send_power(pick_base(), pick_exponent());
        end
    endtask

    // back-to-back requests with no idling at all
    task automatic test_back_to_back();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_modulus(OP_W'($urandom));
        repeat (20)
            send_power(pick_base(), pick_exponent());
    endtask

    // test sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        modulus   = '0;
        in_valid  = 1'b0;
        base      = '0;
        exponent  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_modulus();
        test_modulus_one();
        test_modulus_wrap();
        test_modulus_max();
        test_output_backpressure();
        test_random_phases();
        test_back_to_back();

        src_release();
        wait (power_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d results checked, %0d modulus writes",
                 requests_sent, results_checked, modulus_writes);
        $display("moduli: reset value, one, zero as 2^31, 2^31-1, random; long output hold-off");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #25000000;
        $display("timeout with %0d results pending", power_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
